@@ rtl/fpga_slave_spi_config_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// fpga slave-spi configuration sequencer - assertion macros
// shared property shorthands for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef FPGA_SLAVE_SPI_CONFIG_SEQUENCER_CORE_ASSERT_SVH
`define FPGA_SLAVE_SPI_CONFIG_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FSSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fssc_pkg.sv @@
// ----------------------------------------------------------------------------
// fssc_pkg
// types, codes and constants of the slave-spi configuration sequencer
// ----------------------------------------------------------------------------
package fssc_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INITN_TIMEOUT = 3'd0,
    REG_DONE_TIMEOUT  = 3'd1,
    REG_BUSY_TIMEOUT  = 3'd2,
    REG_BUSY_GAP      = 3'd3,
    REG_PROG_PULSE    = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] InitnTimeoutRst = 16'd200;
  localparam logic [15:0] DoneTimeoutRst  = 16'd500;
  localparam logic [15:0] BusyTimeoutRst  = 16'd1000;
  localparam logic [15:0] BusyGapRst      = 16'd30;
  localparam logic [15:0] ProgPulseRst    = 16'd1000;

  typedef enum logic [2:0] {
    ACT_START      = 3'd0,
    ACT_TICK       = 3'd1,
    ACT_RX_BYTE    = 3'd2,
    ACT_IMAGE_BYTE = 3'd3,
    ACT_SPI_FAULT  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CMD_PIN   = 3'd0,
    CMD_CS    = 3'd1,
    CMD_TX    = 3'd2,
    CMD_RX    = 3'd3,
    CMD_DELAY = 3'd4,
    CMD_FIN   = 3'd5
  } cmd_kind_e;

  typedef enum logic [1:0] {
    FIN_OK         = 2'd0,
    FIN_SPI_ERR    = 2'd1,
    FIN_TIMEOUT    = 2'd2,
    FIN_STATUS_ERR = 2'd3
  } fin_status_e;

  // command opcodes
  localparam logic [7:0] OpEnable   = 8'hC6;
  localparam logic [7:0] OpDisable  = 8'h26;
  localparam logic [7:0] OpErase    = 8'h0E;
  localparam logic [7:0] OpReadStat = 8'h3C;
  localparam logic [7:0] OpBusy     = 8'hF0;
  localparam logic [7:0] OpInitAddr = 8'h46;
  localparam logic [7:0] OpBurst    = 8'h7A;
  localparam logic [7:0] EraseArg   = 8'h01;

  localparam logic [31:0] StatFail = 32'h0000_2000;
  localparam logic [31:0] StatErr  = 32'h0380_0000;

  // a run is up to three segments; a segment is one command or a command word
  typedef enum logic [1:0] {
    SEG_NONE = 2'd0,
    SEG_ONE  = 2'd1,
    SEG_WORD = 2'd2
  } seg_type_e;

  // what follows the four bytes of a command word
  typedef enum logic [1:0] {
    TAIL_OPEN = 2'd0,
    TAIL_CS   = 2'd1,
    TAIL_RX   = 2'd2
  } word_tail_e;

  typedef struct packed {
    seg_type_e   typ;
    cmd_kind_e   kind;
    logic [15:0] value;  // command value, or {opcode, second byte} for a word
    word_tail_e  tail;
  } seg_t;

  localparam int unsigned SegsPerRun = 3;
  localparam int unsigned SegIdxW    = 2;

  typedef struct packed {
    seg_t [SegsPerRun-1:0] seg;
  } run_t;

  localparam int unsigned WordStepW = 3;
  localparam logic [WordStepW-1:0] WordStepOpenLast = 3'd4;
  localparam logic [WordStepW-1:0] WordStepLast     = 3'd5;

  localparam seg_t SegNone = '{typ: SEG_NONE, kind: CMD_PIN, value: 16'h0000, tail: TAIL_OPEN};

  function automatic seg_t seg_one(cmd_kind_e kind, logic [15:0] value);
    seg_t s;
    s.typ   = SEG_ONE;
    s.kind  = kind;
    s.value = value;
    s.tail  = TAIL_OPEN;
    return s;
  endfunction

  function automatic seg_t seg_fin(fin_status_e st);
    return seg_one(CMD_FIN, {14'd0, st});
  endfunction

  function automatic seg_t seg_word(logic [7:0] op, logic [7:0] second, word_tail_e tail);
    seg_t s;
    s.typ   = SEG_WORD;
    s.kind  = CMD_TX;
    s.value = {op, second};
    s.tail  = tail;
    return s;
  endfunction

endpackage

@@ rtl/fssc_front.sv @@
// ----------------------------------------------------------------------------
// fssc_front
// accepts input items, tracks the configuration phase and builds command runs
// ----------------------------------------------------------------------------
module fssc_front import fssc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          in_action_i,
  input  logic                in_image_present_i,
  input  logic                in_pin_initn_i,
  input  logic                in_pin_done_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output run_t                q_run_o
);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_INITN  = 3'd1,
    PH_BUSY_ENABLE = 3'd2,
    PH_BUSY_ERASE  = 3'd3,
    PH_IMAGE       = 3'd4,
    PH_BUSY_FINAL  = 3'd5,
    PH_STATUS      = 3'd6,
    PH_WAIT_DONE   = 3'd7
  } phase_e;

  localparam logic [2:0] StatusBytes = 3'd4;

  logic [15:0] initn_to_q, done_to_q, busy_to_q, busy_gap_q, prog_pulse_q;

  phase_e      phase_q, phase_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [31:0] status_q, status_d;
  logic [2:0]  stat_cnt_q, stat_cnt_d;

  logic        accept;
  logic        busy_phase;
  logic [15:0] elapsed_inc;
  logic [31:0] status_shift;
  logic [2:0]  stat_cnt_inc;
  logic        status_bad;
  run_t        run;

  assign in_ready_o   = !q_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign busy_phase   = (phase_q == PH_BUSY_ENABLE) || (phase_q == PH_BUSY_ERASE) ||
                        (phase_q == PH_BUSY_FINAL);
  // millisecond count saturates
  assign elapsed_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign status_shift = {status_q[23:0], in_byte_i};
  assign stat_cnt_inc = stat_cnt_q + 3'd1;
  assign status_bad   = ((status_shift & StatFail) != 32'd0) ||
                        ((status_shift & StatErr) != 32'd0);

  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    status_d   = status_q;
    stat_cnt_d = stat_cnt_q;
    run.seg[0] = SegNone;
    run.seg[1] = SegNone;
    run.seg[2] = SegNone;

    case (action_e'(in_action_i))
      ACT_START: begin
        if (phase_q == PH_IDLE) begin
          if (!in_image_present_i) begin
            run.seg[0] = seg_fin(FIN_STATUS_ERR);
          end else begin
            run.seg[0] = seg_one(CMD_PIN, 16'd0);
            run.seg[1] = seg_one(CMD_DELAY, prog_pulse_q);
            run.seg[2] = seg_one(CMD_PIN, 16'd1);
            phase_d    = PH_WAIT_INITN;
            elapsed_d  = 16'd0;
          end
        end
      end
      ACT_TICK: begin
        if (phase_q == PH_WAIT_INITN) begin
          if (in_pin_initn_i) begin
            run.seg[0] = seg_word(OpEnable, 8'h00, TAIL_CS);
            run.seg[1] = seg_word(OpBusy, 8'h00, TAIL_RX);
            phase_d    = PH_BUSY_ENABLE;
            elapsed_d  = 16'd0;
          end else begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= initn_to_q) begin
              run.seg[0] = seg_fin(FIN_TIMEOUT);
              phase_d    = PH_IDLE;
            end
          end
        end else if (phase_q == PH_WAIT_DONE) begin
          if (in_pin_done_i) begin
            run.seg[0] = seg_fin(FIN_OK);
            phase_d    = PH_IDLE;
          end else begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= done_to_q) begin
              run.seg[0] = seg_fin(FIN_TIMEOUT);
              phase_d    = PH_IDLE;
            end
          end
        end else if (busy_phase) begin
          elapsed_d = elapsed_inc;
        end
      end
      ACT_RX_BYTE: begin
        if (busy_phase) begin
          run.seg[0] = seg_one(CMD_CS, 16'd1);
          if (in_byte_i == 8'h00) begin
            case (phase_q)
              PH_BUSY_ENABLE: begin
                run.seg[1] = seg_word(OpErase, EraseArg, TAIL_CS);
                run.seg[2] = seg_word(OpBusy, 8'h00, TAIL_RX);
                phase_d    = PH_BUSY_ERASE;
                elapsed_d  = 16'd0;
              end
              PH_BUSY_ERASE: begin
                run.seg[1] = seg_word(OpInitAddr, 8'h00, TAIL_CS);
                run.seg[2] = seg_word(OpBurst, 8'h00, TAIL_OPEN);
                phase_d    = PH_IMAGE;
              end
              default: begin
                run.seg[1] = seg_word(OpReadStat, 8'h00, TAIL_RX);
                status_d   = 32'd0;
                stat_cnt_d = 3'd0;
                phase_d    = PH_STATUS;
              end
            endcase
          end else begin
            run.seg[1] = seg_one(CMD_DELAY, busy_gap_q);
            if (elapsed_q >= busy_to_q) begin
              run.seg[2] = seg_fin(FIN_TIMEOUT);
              phase_d    = PH_IDLE;
            end else begin
              run.seg[2] = seg_word(OpBusy, 8'h00, TAIL_RX);
            end
          end
        end else if (phase_q == PH_STATUS) begin
          status_d   = status_shift;
          stat_cnt_d = stat_cnt_inc;
          if (stat_cnt_inc < StatusBytes) begin
            run.seg[0] = seg_one(CMD_RX, 16'd0);
          end else begin
            run.seg[0] = seg_one(CMD_CS, 16'd1);
            if (status_bad) begin
              run.seg[1] = seg_fin(FIN_STATUS_ERR);
              phase_d    = PH_IDLE;
            end else begin
              run.seg[1] = seg_word(OpDisable, 8'h00, TAIL_CS);
              phase_d    = PH_WAIT_DONE;
              elapsed_d  = 16'd0;
            end
          end
        end
      end
      ACT_IMAGE_BYTE: begin
        if (phase_q == PH_IMAGE) begin
          run.seg[0] = seg_one(CMD_TX, {8'h00, in_byte_i});
          if (in_last_i) begin
            run.seg[1] = seg_one(CMD_CS, 16'd1);
            run.seg[2] = seg_word(OpBusy, 8'h00, TAIL_RX);
            phase_d    = PH_BUSY_FINAL;
            elapsed_d  = 16'd0;
          end
        end
      end
      ACT_SPI_FAULT: begin
        if (busy_phase) begin
          run.seg[0] = seg_one(CMD_CS, 16'd1);
          run.seg[1] = seg_fin(FIN_TIMEOUT);
          phase_d    = PH_IDLE;
        end else if ((phase_q == PH_IMAGE) || (phase_q == PH_STATUS)) begin
          run.seg[0] = seg_one(CMD_CS, 16'd1);
          run.seg[1] = seg_fin(FIN_SPI_ERR);
          phase_d    = PH_IDLE;
        end else if (phase_q == PH_WAIT_DONE) begin
          run.seg[0] = seg_fin(FIN_SPI_ERR);
          phase_d    = PH_IDLE;
        end
      end
      default: begin
        // unused action codes are dropped
      end
    endcase
  end

  assign q_push_o = accept && (run.seg[0].typ != SEG_NONE);
  assign q_run_o  = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= 16'd0;
      status_q   <= 32'd0;
      stat_cnt_q <= 3'd0;
    end else if (accept) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      status_q   <= status_d;
      stat_cnt_q <= stat_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initn_to_q   <= InitnTimeoutRst;
      done_to_q    <= DoneTimeoutRst;
      busy_to_q    <= BusyTimeoutRst;
      busy_gap_q   <= BusyGapRst;
      prog_pulse_q <= ProgPulseRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INITN_TIMEOUT: initn_to_q   <= cfg_data_i;
        REG_DONE_TIMEOUT:  done_to_q    <= cfg_data_i;
        REG_BUSY_TIMEOUT:  busy_to_q    <= cfg_data_i;
        REG_BUSY_GAP:      busy_gap_q   <= cfg_data_i;
        REG_PROG_PULSE:    prog_pulse_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/fssc_queue.sv @@
// ----------------------------------------------------------------------------
// fssc_queue
// small first-in first-out queue of command runs between front and back
// ----------------------------------------------------------------------------
module fssc_queue import fssc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_run_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output run_t pop_run_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign pop_run_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule

@@ rtl/fssc_back.sv @@
// ----------------------------------------------------------------------------
// fssc_back
// expands queued runs into single commands, one per cycle while not stalled
// ----------------------------------------------------------------------------
`include "fpga_slave_spi_config_sequencer_core_assert.svh"

module fssc_back import fssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  run_t        q_run_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cmd_kind_e   out_kind_o,
  output logic [15:0] out_value_o,
  output fin_status_e out_fin_o,
  output logic        out_last_o
);

  run_t                 cur_q;
  logic                 cur_valid_q;
  logic [SegIdxW-1:0]   seg_q;
  logic [WordStepW-1:0] step_q;

  logic        out_valid_q;
  cmd_kind_e   out_kind_q;
  logic [15:0] out_value_q;
  fin_status_e out_fin_q;
  logic        out_last_q;

  seg_t        seg;
  cmd_kind_e   res_kind;
  logic [15:0] res_value;
  fin_status_e res_status;
  logic        seg_end;
  logic        run_end;
  logic        adv;

  assign seg = cur_q.seg[seg_q];

  always_comb begin
    res_kind  = seg.kind;
    res_value = seg.value;
    seg_end   = 1'b1;
    case (seg.typ)
      SEG_ONE: begin
        res_kind  = seg.kind;
        res_value = seg.value;
      end
      SEG_WORD: begin
        // chip select low, opcode, second byte, two zero bytes, then the tail unless it is open
        seg_end = (step_q == ((seg.tail == TAIL_OPEN) ? WordStepOpenLast : WordStepLast));
        case (step_q)
          3'd0: begin
            res_kind  = CMD_CS;
            res_value = 16'd0;
          end
          3'd1: begin
            res_kind  = CMD_TX;
            res_value = {8'h00, seg.value[15:8]};
          end
          3'd2: begin
            res_kind  = CMD_TX;
            res_value = {8'h00, seg.value[7:0]};
          end
          3'd3, 3'd4: begin
            res_kind  = CMD_TX;
            res_value = 16'd0;
          end
          default: begin
            if (seg.tail == TAIL_RX) begin
              res_kind  = CMD_RX;
              res_value = 16'd0;
            end else begin
              res_kind  = CMD_CS;
              res_value = 16'd1;
            end
          end
        endcase
      end
      default: begin
        res_kind  = CMD_FIN;
        res_value = 16'd0;
      end
    endcase
  end

  always_comb begin
    if (seg_q == SegIdxW'(SegsPerRun - 1)) begin
      run_end = seg_end;
    end else begin
      run_end = seg_end && (cur_q.seg[seg_q + SegIdxW'(1)].typ == SEG_NONE);
    end
  end

  assign res_status = (res_kind == CMD_FIN) ? fin_status_e'(res_value[1:0]) : FIN_OK;
  assign adv        = cur_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o    = q_valid_i && (!cur_valid_q || (adv && run_end));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      seg_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
        seg_q       <= '0;
        step_q      <= '0;
      end else if (adv) begin
        if (run_end) begin
          cur_valid_q <= 1'b0;
        end else if (seg_end) begin
          seg_q  <= seg_q + SegIdxW'(1);
          step_q <= '0;
        end else begin
          step_q <= step_q + WordStepW'(1);
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_run_i;
    end
    if (adv) begin
      out_kind_q  <= res_kind;
      out_value_q <= res_value;
      out_fin_q   <= res_status;
      out_last_q  <= run_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_fin_o   = out_fin_q;
  assign out_last_o  = out_last_q;

  `FSSC_ASSERT_IMPL(a_step_range, clk_i, rst_ni, cur_valid_q, step_q <= WordStepLast, "bad step")
  `FSSC_ASSERT_IMPL(a_seg_range, clk_i, rst_ni, cur_valid_q, seg_q != SegIdxW'(SegsPerRun), "bad seg")
  `FSSC_ASSERT_IMPL(a_fin_last, clk_i, rst_ni, out_valid_q && (out_kind_q == CMD_FIN), out_last_q, "fin not last")
  `FSSC_ASSERT_IMPL(a_status_fin, clk_i, rst_ni, out_valid_q && (out_kind_q != CMD_FIN), out_fin_q == FIN_OK, "bad status")
  `FSSC_ASSERT_NEXT(a_run_holds, clk_i, rst_ni, adv && !run_end, cur_valid_q, "run dropped")

endmodule

@@ rtl/fpga_slave_spi_config_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// fpga_slave_spi_config_sequencer_core
// slave-spi configuration sequencer: events in, pin and spi commands out
// ----------------------------------------------------------------------------
// input stream: one event per transaction (start, millisecond tick, received
// byte, image byte, spi fault) with pin levels and the byte in tdata, the
// action code in tuser and the last-image-byte flag in tlast.
// output stream: one command per transaction (program pin, chip select,
// transmit, receive, delay, finished); tlast marks the last command caused by
// an event. an event gives from zero up to thirteen commands.
// the front decodes each event against the sequencing phase combinationally
// and writes the command run into a queue of QueueDepth runs; the back expands
// one run at a time at one command per cycle while the output is not stalled.
// an event's run is registered in the queue, then in the back's current run,
// and its first command is registered at the output. events are taken every
// cycle while the queue has room. configuration registers must be written
// through the cfg port while idle; the sequencer has no check for this.
// reset puts the sequencer idle, clears the queue and restores the register
// defaults. a stalled output holds its command; the back then stops, the queue
// fills and s_axis_tready falls once QueueDepth runs are waiting.
// ----------------------------------------------------------------------------
module fpga_slave_spi_config_sequencer_core import fssc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // image_present, pin_initn, pin_done, byte_value
  input  logic [2:0]          s_axis_tuser,   // action
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // command_value, final_status
  output logic [2:0]          m_axis_tuser,   // command_kind
  output logic                m_axis_tlast
);

  logic        q_full, q_push, q_pop, q_valid;
  run_t        push_run, pop_run;
  cmd_kind_e   out_kind;
  logic [15:0] out_value;
  fin_status_e out_fin;

  fssc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .in_action_i        (s_axis_tuser),
    .in_image_present_i (s_axis_tdata[0]),
    .in_pin_initn_i     (s_axis_tdata[1]),
    .in_pin_done_i      (s_axis_tdata[2]),
    .in_byte_i          (s_axis_tdata[10:3]),
    .in_last_i          (s_axis_tlast),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_run_o            (push_run)
  );

  fssc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_run_i (push_run),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_run_o  (pop_run)
  );

  fssc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_run_i     (pop_run),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_value_o (out_value),
    .out_fin_o   (out_fin),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'd0, out_fin, out_value};

endmodule

@@ tb/fpga_slave_spi_config_sequencer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpga_slave_spi_config_sequencer_core_test
// drives event transactions into the sequencer and checks every command that
// comes out against an in-bench model of the configuration sequence; a short
// directed table walks one full configuration, then random well-formed runs
// with some noise follow under several register settings
// ----------------------------------------------------------------------------
module fpga_slave_spi_config_sequencer_core_test;
  import fssc_pkg::*;

  localparam int unsigned NumRegs       = 5;
  localparam int unsigned NumDirected   = 26;
  localparam int unsigned NumRandPhases = 6;
  localparam int unsigned ItemsPerPhase = 58;
  localparam int unsigned MaxCmdsPerEvt = 13;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned CycleLimit    = 1000000;
  localparam logic [2:0]  ActUnused     = 3'd7;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WAIT_INITN,
    SEQ_BUSY_ENABLE,
    SEQ_BUSY_ERASE,
    SEQ_IMAGE,
    SEQ_BUSY_FINAL,
    SEQ_STATUS,
    SEQ_WAIT_DONE
  } seq_phase_e;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_FINISH
  } row_check_e;

  typedef struct packed {
    logic [2:0] action;
    logic       present;
    logic       initn;
    logic       done;
    logic [7:0] data;
    logic       last;
  } seq_event_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } cmd_t;

  typedef struct packed {
    seq_event_t  ev;
    row_check_e  chk;
    fin_status_e fin;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // image_present, pin_initn, pin_done, byte_value
  logic [2:0]          s_axis_tuser = '0;   // action
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // command_value, final_status
  logic [2:0]          m_axis_tuser;        // command_kind
  logic                m_axis_tlast;

  // model state and register copy
  seq_phase_e  seq_phase = SEQ_IDLE;
  logic [15:0] elapsed_ms = '0;
  logic [31:0] status_word = '0;
  logic [2:0]  status_cnt = '0;
  logic [15:0] cfg_regs [NumRegs];
  logic [15:0] next_regs [NumRegs];

  cmd_t        run_cmds [$];
  cmd_t        pending_cmds [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit          rx_steady = 1'b0;
  bit          tx_steady = 1'b0;

  fpga_slave_spi_config_sequencer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic void put_cmd(cmd_kind_e kind, logic [15:0] value);
    cmd_t c;
    if (run_cmds.size() >= MaxCmdsPerEvt) return;
    c.kind   = kind;
    c.value  = value;
    c.status = (kind == CMD_FIN) ? value[1:0] : 2'd0;
    c.last   = 1'b0;
    run_cmds.push_back(c);
  endfunction

  function automatic void put_finish(fin_status_e st);
    put_cmd(CMD_FIN, {14'd0, st});
    seq_phase = SEQ_IDLE;
  endfunction

  // command word: chip select low, opcode, second byte, two zero bytes
  function automatic void put_word(logic [7:0] op, logic [7:0] second, bit close);
    put_cmd(CMD_CS, 16'd0);
    put_cmd(CMD_TX, {8'd0, op});
    put_cmd(CMD_TX, {8'd0, second});
    put_cmd(CMD_TX, 16'd0);
    put_cmd(CMD_TX, 16'd0);
    if (close) put_cmd(CMD_CS, 16'd1);
  endfunction

  function automatic void put_poll();
    put_word(OpBusy, 8'd0, 1'b0);
    put_cmd(CMD_RX, 16'd0);
  endfunction

  function automatic void enter_poll(seq_phase_e nxt);
    seq_phase  = nxt;
    elapsed_ms = '0;
    put_poll();
  endfunction

  function automatic void count_tick();
    if (elapsed_ms != 16'hFFFF) elapsed_ms++;
  endfunction

  function automatic void predict_commands(seq_event_t ev);
    logic busy_wait;
    busy_wait = (seq_phase == SEQ_BUSY_ENABLE) || (seq_phase == SEQ_BUSY_ERASE) ||
                (seq_phase == SEQ_BUSY_FINAL);
    run_cmds.delete();
    case (ev.action)
      ACT_START: begin
        if (seq_phase == SEQ_IDLE) begin
          if (!ev.present) begin
            put_finish(FIN_STATUS_ERR);
          end else begin
            put_cmd(CMD_PIN, 16'd0);
            put_cmd(CMD_DELAY, cfg_regs[REG_PROG_PULSE]);
            put_cmd(CMD_PIN, 16'd1);
            seq_phase  = SEQ_WAIT_INITN;
            elapsed_ms = '0;
          end
        end
      end
      ACT_TICK: begin
        if (seq_phase == SEQ_WAIT_INITN) begin
          if (ev.initn) begin
            put_word(OpEnable, 8'd0, 1'b1);
            enter_poll(SEQ_BUSY_ENABLE);
          end else begin
            count_tick();
            if (elapsed_ms >= cfg_regs[REG_INITN_TIMEOUT]) put_finish(FIN_TIMEOUT);
          end
        end else if (seq_phase == SEQ_WAIT_DONE) begin
          if (ev.done) begin
            put_finish(FIN_OK);
          end else begin
            count_tick();
            if (elapsed_ms >= cfg_regs[REG_DONE_TIMEOUT]) put_finish(FIN_TIMEOUT);
          end
        end else if (busy_wait) begin
          count_tick();
        end
      end
      ACT_RX_BYTE: begin
        if (busy_wait) begin
          put_cmd(CMD_CS, 16'd1);
          if (ev.data == 8'd0) begin
            case (seq_phase)
              SEQ_BUSY_ENABLE: begin
                put_word(OpErase, EraseArg, 1'b1);
                enter_poll(SEQ_BUSY_ERASE);
              end
              SEQ_BUSY_ERASE: begin
                put_word(OpInitAddr, 8'd0, 1'b1);
                put_word(OpBurst, 8'd0, 1'b0);
                seq_phase = SEQ_IMAGE;
              end
              default: begin
                put_word(OpReadStat, 8'd0, 1'b0);
                put_cmd(CMD_RX, 16'd0);
                status_word = '0;
                status_cnt  = '0;
                seq_phase   = SEQ_STATUS;
              end
            endcase
          end else begin
            put_cmd(CMD_DELAY, cfg_regs[REG_BUSY_GAP]);
            if (elapsed_ms >= cfg_regs[REG_BUSY_TIMEOUT]) put_finish(FIN_TIMEOUT);
            else put_poll();
          end
        end else if (seq_phase == SEQ_STATUS) begin
          // status word arrives most significant byte first
          status_word = {status_word[23:0], ev.data};
          status_cnt  = status_cnt + 3'd1;
          if (status_cnt < 3'd4) begin
            put_cmd(CMD_RX, 16'd0);
          end else begin
            put_cmd(CMD_CS, 16'd1);
            if ((status_word & (StatFail | StatErr)) != 32'd0) begin
              put_finish(FIN_STATUS_ERR);
            end else begin
              put_word(OpDisable, 8'd0, 1'b1);
              seq_phase  = SEQ_WAIT_DONE;
              elapsed_ms = '0;
            end
          end
        end
      end
      ACT_IMAGE_BYTE: begin
        if (seq_phase == SEQ_IMAGE) begin
          put_cmd(CMD_TX, {8'd0, ev.data});
          if (ev.last) begin
            put_cmd(CMD_CS, 16'd1);
            enter_poll(SEQ_BUSY_FINAL);
          end
        end
      end
      ACT_SPI_FAULT: begin
        if (busy_wait) begin
          put_cmd(CMD_CS, 16'd1);
          put_finish(FIN_TIMEOUT);
        end else if (seq_phase == SEQ_IMAGE || seq_phase == SEQ_STATUS) begin
          put_cmd(CMD_CS, 16'd1);
          put_finish(FIN_SPI_ERR);
        end else if (seq_phase == SEQ_WAIT_DONE) begin
          put_finish(FIN_SPI_ERR);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic dir_row_t mk_row(logic [2:0] act, logic present, logic initn,
                                      logic done, logic [7:0] data, logic last,
                                      row_check_e chk, fin_status_e fin);
    dir_row_t r;
    r.ev.action  = act;
    r.ev.present = present;
    r.ev.initn   = initn;
    r.ev.done    = done;
    r.ev.data    = data;
    r.ev.last    = last;
    r.chk        = chk;
    r.fin        = fin;
    return r;
  endfunction

  // one full configuration under reset register values, with ignored events
  function automatic dir_row_t directed_row(int unsigned i);
    case (i)
      0:  return mk_row(ACT_TICK,       0, 1, 1, 8'h00, 0, ROW_SILENT,  FIN_OK);
      1:  return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'hFF, 0, ROW_SILENT,  FIN_OK);
      2:  return mk_row(ACT_IMAGE_BYTE, 1, 0, 0, 8'hFF, 1, ROW_SILENT,  FIN_OK);
      3:  return mk_row(ACT_SPI_FAULT,  0, 0, 0, 8'h00, 0, ROW_SILENT,  FIN_OK);
      4:  return mk_row(ActUnused,      1, 1, 1, 8'hFF, 1, ROW_SILENT,  FIN_OK);
      5:  return mk_row(ACT_START,      0, 0, 0, 8'h00, 0, ROW_FINISH,  FIN_STATUS_ERR);
      6:  return mk_row(ACT_START,      1, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      7:  return mk_row(ACT_START,      1, 1, 1, 8'hFF, 1, ROW_SILENT,  FIN_OK);
      8:  return mk_row(ACT_SPI_FAULT,  0, 0, 0, 8'h00, 0, ROW_SILENT,  FIN_OK);
      9:  return mk_row(ACT_TICK,       0, 0, 1, 8'h00, 0, ROW_SILENT,  FIN_OK);
      10: return mk_row(ACT_TICK,       0, 1, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      11: return mk_row(ACT_TICK,       0, 0, 0, 8'h00, 0, ROW_SILENT,  FIN_OK);
      12: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h01, 0, ROW_PREDICT, FIN_OK);
      13: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      14: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h80, 0, ROW_PREDICT, FIN_OK);
      15: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      16: return mk_row(ACT_IMAGE_BYTE, 0, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      17: return mk_row(ACT_IMAGE_BYTE, 0, 0, 0, 8'hFF, 0, ROW_PREDICT, FIN_OK);
      18: return mk_row(ACT_IMAGE_BYTE, 0, 0, 0, 8'hA5, 1, ROW_PREDICT, FIN_OK);
      19: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
      20: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'hFC, 0, ROW_PREDICT, FIN_OK);
      21: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'h7F, 0, ROW_PREDICT, FIN_OK);
      22: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'hDF, 0, ROW_PREDICT, FIN_OK);
      23: return mk_row(ACT_RX_BYTE,    0, 0, 0, 8'hFF, 0, ROW_PREDICT, FIN_OK);
      24: return mk_row(ACT_TICK,       0, 1, 0, 8'h00, 0, ROW_SILENT,  FIN_OK);
      default: return mk_row(ACT_TICK,  0, 0, 1, 8'h00, 0, ROW_FINISH,  FIN_OK);
    endcase
  endfunction

  // mostly the event the sequence is waiting for, with random content
  function automatic seq_event_t pick_event();
    seq_event_t  ev;
    int unsigned r;
    logic [31:0] err_bits;
    ev       = seq_event_t'($urandom_range(0, 32767));
    r        = $urandom_range(0, 99);
    err_bits = StatFail | StatErr;
    if (r < 8) return ev;
    case (seq_phase)
      SEQ_IDLE: begin
        ev.action  = ACT_START;
        ev.present = ($urandom_range(0, 9) != 0);
      end
      SEQ_WAIT_INITN: begin
        ev.action = ACT_TICK;
        ev.initn  = ($urandom_range(0, 3) == 0);
      end
      SEQ_IMAGE: begin
        ev.action = (r < 11) ? ACT_SPI_FAULT : ACT_IMAGE_BYTE;
        ev.last   = ($urandom_range(0, 5) == 0);
      end
      SEQ_STATUS: begin
        ev.action = (r < 10) ? ACT_SPI_FAULT : ACT_RX_BYTE;
        // keep the fail bit and error field clear in most words
        if ($urandom_range(0, 9) != 0) ev.data &= ~err_bits[8*(3-status_cnt) +: 8];
      end
      SEQ_WAIT_DONE: begin
        ev.action = (r < 11) ? ACT_SPI_FAULT : ACT_TICK;
        ev.done   = ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (r < 11) ev.action = ACT_SPI_FAULT;
        else if (r < 31) ev.action = ACT_TICK;
        else ev.action = ACT_RX_BYTE;
        if (ev.action == ACT_RX_BYTE && $urandom_range(0, 1) == 0) ev.data = 8'd0;
      end
    endcase
    return ev;
  endfunction

  task automatic send_event(seq_event_t ev, bit queue_prediction);
    int unsigned gap;
    cmd_t        c;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, ev.data, ev.done, ev.initn, ev.present};
    s_axis_tuser  <= ev.action;
    s_axis_tlast  <= ev.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_commands(ev);
    if (queue_prediction) begin
      foreach (run_cmds[i]) begin
        c      = run_cmds[i];
        c.last = (i == run_cmds.size() - 1);
        pending_cmds.push_back(c);
      end
    end
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings();
    cfg_we_i <= 1'b1;
    for (int r = 0; r < NumRegs; r++) begin
      cfg_idx_i  <= cfg_reg_e'(r);
      cfg_data_i <= next_regs[r];
      @(posedge clk_i);
      cfg_regs[r] = next_regs[r];
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : command_sink
    cmd_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: command with none pending: kind %0d value %h status %0d last %0d",
                   $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[17:16],
                   m_axis_tlast);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[15:0] !== want.value ||
              m_axis_tdata[17:16] !== want.status || m_axis_tlast !== want.last) begin
            $display("%0t: expected kind %0d value %h status %0d last %0d", $time,
                     want.kind, want.value, want.status, want.last);
            $display("%0t: actual   kind %0d value %h status %0d last %0d", $time,
                     m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tlast);
            mismatches++;
          end
        end
        rx_hold = rx_steady ? 0 : $urandom_range(0, 14);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      m_axis_tready <= (rx_hold == 0);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    dir_row_t row;
    cmd_t     fin_cmd;
    cfg_regs[REG_INITN_TIMEOUT] = InitnTimeoutRst;
    cfg_regs[REG_DONE_TIMEOUT]  = DoneTimeoutRst;
    cfg_regs[REG_BUSY_TIMEOUT]  = BusyTimeoutRst;
    cfg_regs[REG_BUSY_GAP]      = BusyGapRst;
    cfg_regs[REG_PROG_PULSE]    = ProgPulseRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int unsigned i = 0; i < NumDirected; i++) begin
      row = directed_row(i);
      send_event(row.ev, row.chk == ROW_PREDICT);
      if (row.chk == ROW_FINISH) begin
        fin_cmd.kind   = CMD_FIN;
        fin_cmd.value  = {14'd0, row.fin};
        fin_cmd.status = row.fin;
        fin_cmd.last   = 1'b1;
        pending_cmds.push_back(fin_cmd);
      end
    end

    for (int p = 0; p < NumRandPhases; p++) begin
      // registers are only touched with the sequence idle and nothing in flight
      if (seq_phase == SEQ_WAIT_INITN) begin
        row = mk_row(ACT_TICK, 0, 1, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
        send_event(row.ev, 1'b1);
      end
      if (seq_phase != SEQ_IDLE) begin
        row = mk_row(ACT_SPI_FAULT, 0, 0, 0, 8'h00, 0, ROW_PREDICT, FIN_OK);
        send_event(row.ev, 1'b1);
      end
      wait_until_drained();
      for (int r = 0; r < NumRegs; r++) begin
        case (p)
          0: next_regs[r] = 16'hFFFF;
          1: next_regs[r] = 16'h0000;
          2: next_regs[r] = 16'h0001;
          3: next_regs[r] = (r <= REG_BUSY_TIMEOUT) ? 16'($urandom_range(1, 6))
                                                    : 16'($urandom_range(0, 65535));
          default: next_regs[r] = (r <= REG_BUSY_TIMEOUT) ? 16'($urandom_range(2, 40))
                                                          : 16'($urandom_range(0, 400));
        endcase
      end
      apply_settings();
      repeat (ItemsPerPhase) send_event(pick_event(), 1'b1);
    end

    wait_until_drained();
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fssc_pkg.sv
rtl/fssc_front.sv
rtl/fssc_queue.sv
rtl/fssc_back.sv
rtl/fpga_slave_spi_config_sequencer_core.sv
tb/fpga_slave_spi_config_sequencer_core_test.sv
